@@ rtl/core/rhss_pkg.sv @@
// ----------------------------------------------------------------------------
// rhss_pkg
// Shared types, constants and arithmetic helpers of the regression
// histogram split search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rhss_pkg;

    localparam int MAX_BINS_DEF = 64;

    // field widths
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 48;
    localparam int SQ_W     = 63;
    localparam int COST_W   = 64;
    localparam int CUT_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COST_MARGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE    = 1'b1;

    localparam logic signed [COST_W-1:0] COST_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DEF_MUL,
        ST_DEF_DIV,
        ST_MARGIN,
        ST_MEAN,
        ST_RD,
        ST_ACC,
        ST_QA_MUL,
        ST_QA_DIV,
        ST_QB_MUL,
        ST_QB_DIV,
        ST_CMP,
        ST_XA,
        ST_XB,
        ST_FIN
    } t_state;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    // magnitude of a signed 64 bit value
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    // l2 - qa - qb, saturated to signed 64 bits
    function automatic logic signed [63:0] cost_sub(input logic [SQ_W-1:0] l2,
                                                    input logic [63:0] qa,
                                                    input logic [63:0] qb);
        logic [64:0] s;
        logic [64:0] d;
        logic [64:0] l2x;
        logic signed [63:0] res;
        l2x = {2'b00, l2};
        s   = {1'b0, qa} + {1'b0, qb};
        d   = s - l2x;
        if (s[64]) begin
            res = COST_MIN;
        end else if (s <= l2x) begin
            res = signed'(64'(l2x - s));
        end else if (d[64:63] != 2'b00) begin
            res = COST_MIN;
        end else begin
            res = -signed'(d[63:0]);
        end
        cost_sub = res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rhss_ram.sv @@
// ----------------------------------------------------------------------------
// rhss_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rhss_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/rhss_mdu.sv @@
// ----------------------------------------------------------------------------
// rhss_mdu
// Iterative multiply/divide unit: 64x64 shift-add multiply and 128/64
// restoring divide with saturation, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rhss_mdu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rhss_pkg::t_mdu_req i_req,
    input  wire logic [127:0]      i_x,
    input  wire logic [63:0]       i_y,
    output logic                   o_done,
    output logic [127:0]           o_res
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    rhss_pkg::t_mdu_op r_op, n_op;
    logic [5:0]        r_cnt, n_cnt;
    logic [127:0]      r_acc, n_acc;
    logic [127:0]      r_a, n_a;
    logic [63:0]       r_b, n_b;
    logic [63:0]       r_rem, n_rem;
    logic [63:0]       r_q, n_q;
    logic [64:0]       rem_sh;
    logic [65:0]       rem_sub;

    // restoring divide step
    assign rem_sh  = {r_rem, r_a[63]};
    assign rem_sub = {1'b0, rem_sh} - {2'b00, r_b};

    // next state of the iteration
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_rem  = r_rem;
        n_q    = r_q;
        if (i_req.start && !r_busy) begin
            n_op  = i_req.op;
            n_b   = i_y;
            n_cnt = 6'd63;
            case (i_req.op)
                rhss_pkg::MDU_MUL: begin
                    n_acc  = '0;
                    n_a    = {64'd0, i_x[63:0]};
                    n_busy = 1'b1;
                end
                rhss_pkg::MDU_DIV: begin
                    n_a   = i_x;
                    n_rem = i_x[127:64];
                    n_q   = '0;
                    // quotient overflows 64 bits: saturate at once
                    if (i_x[127:64] >= i_y) begin
                        n_q    = '1;
                        n_done = 1'b1;
                    end else begin
                        n_busy = 1'b1;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                rhss_pkg::MDU_MUL: begin
                    if (r_b[0]) begin
                        n_acc = r_acc + r_a;
                    end
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end
                rhss_pkg::MDU_DIV: begin
                    n_a = r_a << 1;
                    if (!rem_sub[65]) begin
                        n_rem = rem_sub[63:0];
                        n_q   = {r_q[62:0], 1'b1};
                    end else begin
                        n_rem = rem_sh[63:0];
                        n_q   = {r_q[62:0], 1'b0};
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= rhss_pkg::MDU_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_res  = (r_op == rhss_pkg::MDU_MUL) ? r_acc : {64'd0, r_q};

endmodule

`default_nettype wire

@@ rtl/core/regression_histogram_split_search_unit.sv @@
// ----------------------------------------------------------------------------
// regression_histogram_split_search_unit
// Best variance split over one histogram of bins for a regression tree.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one histogram bin each (weight, response sum); the
//   word with i_last_bin set also carries the node's squared-response
//   total and closes the histogram. Bins load at one word per cycle while
//   o_stall is low into a bin RAM as totals accumulate; bins beyond
//   MAX_BINS are dropped. After the last bin, o_stall stays high while the
//   search runs: all multiplies and divides go through one bit-serial unit.
//   The no-split cost, margin and mean come first, then each cut costs one
//   RAM read plus up to six operations. A zero total weight skips the
//   search and goes straight to the result. One output word follows per
//   histogram; it waits in an output register while i_stall is high, and
//   loading of the next histogram goes on meanwhile. The configuration port
//   is always ready. Reset (synchronous, active low) clears the bin count,
//   totals, control and configuration registers and output valid; the bin
//   RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module regression_histogram_split_search_unit #(
    parameter int MAX_BINS = rhss_pkg::MAX_BINS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // bin input channel
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [rhss_pkg::WEIGHT_W-1:0]        i_bin_weight,
    input  wire logic signed [rhss_pkg::SUM_W-1:0]    i_bin_response_sum,
    input  wire logic [rhss_pkg::SQ_W-1:0]            i_response_square_total,
    input  wire logic                                 i_last_bin,
    // result channel
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [rhss_pkg::CUT_W-1:0]                o_split_bin,
    output logic signed [rhss_pkg::COST_W-1:0]        o_best_cost,
    output logic                                      o_found,
    output logic signed [rhss_pkg::COST_W-1:0]        o_base_cost,
    output logic signed [rhss_pkg::SUM_W-1:0]         o_prediction_mean,
    // configuration write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [rhss_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [rhss_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW    = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int TW_W  = rhss_pkg::WEIGHT_W + AW;
    localparam int TS_W  = rhss_pkg::SUM_W + AW;
    localparam int RAM_W = rhss_pkg::WEIGHT_W + rhss_pkg::SUM_W;

    rhss_pkg::t_state r_state, n_state;
    logic             r_issued, n_issued;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_i, n_i;
    logic [TW_W-1:0]  r_tw, n_tw;
    logic signed [TS_W-1:0] r_ts, n_ts;
    logic [rhss_pkg::SQ_W-1:0] r_sq, n_sq;
    logic [TW_W-1:0]  r_wl, n_wl, r_wr, n_wr;
    logic signed [TS_W-1:0] r_sl, n_sl, r_sr, n_sr;
    logic [127:0]     r_prod, n_prod;
    logic [127:0]     r_xa, n_xa;
    logic [63:0]      r_qa, n_qa;
    logic signed [63:0] r_cost, n_cost;
    logic signed [63:0] r_best, n_best;
    logic [CNT_W-1:0] r_best_cut, n_best_cut;
    logic             r_found, n_found;
    logic signed [63:0] r_dflt, n_dflt;
    logic signed [rhss_pkg::SUM_W-1:0] r_mean, n_mean;
    logic [15:0]      r_margin, n_margin;
    logic [31:0]      r_min, n_min;
    // output register
    logic             r_out_valid, n_out_valid;
    logic [rhss_pkg::CUT_W-1:0] r_o_cut, n_o_cut;
    logic signed [63:0] r_o_cost, n_o_cost;
    logic             r_o_found, n_o_found;
    logic signed [63:0] r_o_dflt, n_o_dflt;
    logic signed [rhss_pkg::SUM_W-1:0] r_o_mean, n_o_mean;

    // bin RAM and arithmetic unit
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [RAM_W-1:0] ram_rdata;
    rhss_pkg::t_mdu_req mdu_req;
    logic [127:0]     mdu_x;
    logic [63:0]      mdu_y;
    logic             mdu_done;
    logic [127:0]     mdu_res;

    // combinational helpers
    logic             in_acc;
    logic [CNT_W-1:0] i_m1, i_p1;
    logic [TW_W-1:0]  acc_wl, acc_wr;
    logic signed [TS_W-1:0] acc_sl, acc_sr;
    logic [TW_W-1:0]  min_ext;
    logic [16:0]      f_margin;
    logic [63:0]      mar_p, mean_m, mean_nm;
    logic [63:0]      mag_sl, mag_sr, mag_ts;
    logic signed [63:0] cut_cost;
    logic             xa_neg, xb_neg, differ;
    logic [63:0]      cut_ext;

    rhss_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_BINS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata({i_bin_weight, i_bin_response_sum}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    rhss_mdu u_mdu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mdu_req),
        .i_x    (mdu_x),
        .i_y    (mdu_y),
        .o_done (mdu_done),
        .o_res  (mdu_res)
    );

    assign o_stall     = (r_state != rhss_pkg::ST_LOAD);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign i_m1      = r_i - CNT_W'(1);
    assign i_p1      = r_i + CNT_W'(1);
    assign ram_waddr = r_cnt[AW-1:0];
    assign ram_raddr = i_m1[AW-1:0];

    // prefix sums for the cut under test
    assign acc_wl = r_wl + TW_W'(ram_rdata[RAM_W-1:rhss_pkg::SUM_W]);
    assign acc_sl = r_sl + TS_W'(signed'(ram_rdata[rhss_pkg::SUM_W-1:0]));
    assign acc_wr = r_tw - acc_wl;
    assign acc_sr = r_ts - acc_sl;

    assign min_ext  = {{(TW_W - 32){1'b0}}, r_min};
    assign f_margin = 17'h10000 - {1'b0, r_margin};
    assign mar_p    = mdu_res[79:16];
    assign mean_m   = mdu_res[63:0];
    assign mean_nm  = 64'd0 - mean_m;
    assign mag_sl   = rhss_pkg::mag64(64'(r_sl));
    assign mag_sr   = rhss_pkg::mag64(64'(r_sr));
    assign mag_ts   = rhss_pkg::mag64(64'(r_ts));
    assign cut_cost = rhss_pkg::cost_sub(r_sq, r_qa, mdu_res[63:0]);

    // side means compared by cross products
    assign xa_neg = r_sl[TS_W-1] && (r_xa != '0);
    assign xb_neg = r_sr[TS_W-1] && (mdu_res != '0);
    assign differ = (r_xa != mdu_res) || (xa_neg != xb_neg);

    assign cut_ext = 64'(r_best_cut);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_tw        = r_tw;
        n_ts        = r_ts;
        n_sq        = r_sq;
        n_wl        = r_wl;
        n_wr        = r_wr;
        n_sl        = r_sl;
        n_sr        = r_sr;
        n_prod      = r_prod;
        n_xa        = r_xa;
        n_qa        = r_qa;
        n_cost      = r_cost;
        n_best      = r_best;
        n_best_cut  = r_best_cut;
        n_found     = r_found;
        n_dflt      = r_dflt;
        n_mean      = r_mean;
        n_margin    = r_margin;
        n_min       = r_min;
        n_out_valid = r_out_valid;
        n_o_cut     = r_o_cut;
        n_o_cost    = r_o_cost;
        n_o_found   = r_o_found;
        n_o_dflt    = r_o_dflt;
        n_o_mean    = r_o_mean;
        ram_we      = 1'b0;
        mdu_req     = '{start: 1'b0, op: rhss_pkg::MDU_MUL};
        mdu_x       = '0;
        mdu_y       = '0;

        // configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                rhss_pkg::CFG_COST_MARGIN: n_margin = i_cfg_data[15:0];
                rhss_pkg::CFG_MIN_SIDE:    n_min    = i_cfg_data;
                default:                   n_min    = r_min;
            endcase
        end

        // result word taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rhss_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (r_cnt < CNT_W'(MAX_BINS)) begin
                        ram_we = 1'b1;
                        n_cnt  = r_cnt + CNT_W'(1);
                        n_tw   = r_tw + TW_W'(i_bin_weight);
                        n_ts   = r_ts + TS_W'(i_bin_response_sum);
                    end
                    if (i_last_bin) begin
                        n_sq       = i_response_square_total;
                        n_best     = '0;
                        n_best_cut = CNT_W'(1);
                        n_found    = 1'b0;
                        n_dflt     = '0;
                        n_mean     = '0;
                        n_wl       = '0;
                        n_sl       = '0;
                        n_i        = CNT_W'(1);
                        n_state    = (n_tw == '0) ? rhss_pkg::ST_FIN
                                                  : rhss_pkg::ST_DEF_MUL;
                    end
                end
            end
            rhss_pkg::ST_DEF_MUL: begin
                mdu_req.op = rhss_pkg::MDU_MUL;
                mdu_x      = {64'd0, mag_ts};
                mdu_y      = mag_ts;
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    n_prod   = mdu_res;
                    n_state  = rhss_pkg::ST_DEF_DIV;
                end
            end
            rhss_pkg::ST_DEF_DIV: begin
                mdu_req.op = rhss_pkg::MDU_DIV;
                mdu_x      = r_prod;
                mdu_y      = 64'(r_tw);
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    n_dflt   = rhss_pkg::cost_sub(r_sq, mdu_res[63:0], 64'd0);
                    n_state  = rhss_pkg::ST_MARGIN;
                end
            end
            rhss_pkg::ST_MARGIN: begin
                // default * (1 - cp), truncated toward zero
                mdu_req.op = rhss_pkg::MDU_MUL;
                mdu_x      = {64'd0, rhss_pkg::mag64(r_dflt)};
                mdu_y      = 64'(f_margin);
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    if (r_dflt[63]) begin
                        n_best = mar_p[63] ? rhss_pkg::COST_MIN : -signed'(mar_p);
                    end else begin
                        n_best = signed'(mar_p);
                    end
                    n_state = rhss_pkg::ST_MEAN;
                end
            end
            rhss_pkg::ST_MEAN: begin
                mdu_req.op = rhss_pkg::MDU_DIV;
                mdu_x      = {64'd0, mag_ts};
                mdu_y      = 64'(r_tw);
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    if (r_ts[TS_W-1]) begin
                        n_mean = (mean_m > 64'h8000_0000_0000) ? 48'sh8000_0000_0000
                                                               : signed'(mean_nm[47:0]);
                    end else begin
                        n_mean = (mean_m > 64'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF
                                                               : signed'(mean_m[47:0]);
                    end
                    n_state = (r_i < r_cnt) ? rhss_pkg::ST_RD : rhss_pkg::ST_FIN;
                end
            end
            rhss_pkg::ST_RD: begin
                n_state = rhss_pkg::ST_ACC;
            end
            rhss_pkg::ST_ACC: begin
                n_wl = acc_wl;
                n_sl = acc_sl;
                n_wr = acc_wr;
                n_sr = acc_sr;
                // a cut with an empty side is skipped
                if (acc_wl == '0 || acc_wr == '0) begin
                    n_i     = i_p1;
                    n_state = (i_p1 < r_cnt) ? rhss_pkg::ST_RD : rhss_pkg::ST_FIN;
                end else begin
                    n_state = rhss_pkg::ST_QA_MUL;
                end
            end
            rhss_pkg::ST_QA_MUL: begin
                mdu_req.op = rhss_pkg::MDU_MUL;
                mdu_x      = {64'd0, mag_sl};
                mdu_y      = mag_sl;
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    n_prod   = mdu_res;
                    n_state  = rhss_pkg::ST_QA_DIV;
                end
            end
            rhss_pkg::ST_QA_DIV: begin
                mdu_req.op = rhss_pkg::MDU_DIV;
                mdu_x      = r_prod;
                mdu_y      = 64'(r_wl);
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    n_qa     = mdu_res[63:0];
                    n_state  = rhss_pkg::ST_QB_MUL;
                end
            end
            rhss_pkg::ST_QB_MUL: begin
                mdu_req.op = rhss_pkg::MDU_MUL;
                mdu_x      = {64'd0, mag_sr};
                mdu_y      = mag_sr;
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    n_prod   = mdu_res;
                    n_state  = rhss_pkg::ST_QB_DIV;
                end
            end
            rhss_pkg::ST_QB_DIV: begin
                mdu_req.op = rhss_pkg::MDU_DIV;
                mdu_x      = r_prod;
                mdu_y      = 64'(r_wr);
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    n_cost   = cut_cost;
                    n_state  = rhss_pkg::ST_CMP;
                end
            end
            rhss_pkg::ST_CMP: begin
                // better than the best so far, and both sides heavy enough
                if (r_cost < r_best && r_wl >= min_ext && r_wr >= min_ext) begin
                    n_state = rhss_pkg::ST_XA;
                end else begin
                    n_i     = i_p1;
                    n_state = (i_p1 < r_cnt) ? rhss_pkg::ST_RD : rhss_pkg::ST_FIN;
                end
            end
            rhss_pkg::ST_XA: begin
                mdu_req.op = rhss_pkg::MDU_MUL;
                mdu_x      = {64'd0, mag_sl};
                mdu_y      = 64'(r_wr);
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    n_xa     = mdu_res;
                    n_state  = rhss_pkg::ST_XB;
                end
            end
            rhss_pkg::ST_XB: begin
                mdu_req.op = rhss_pkg::MDU_MUL;
                mdu_x      = {64'd0, mag_sr};
                mdu_y      = 64'(r_wl);
                if (!r_issued) begin
                    mdu_req.start = 1'b1;
                    n_issued      = 1'b1;
                end else if (mdu_done) begin
                    n_issued = 1'b0;
                    if (differ) begin
                        n_best     = r_cost;
                        n_best_cut = r_i;
                        n_found    = 1'b1;
                    end
                    n_i     = i_p1;
                    n_state = (i_p1 < r_cnt) ? rhss_pkg::ST_RD : rhss_pkg::ST_FIN;
                end
            end
            rhss_pkg::ST_FIN: begin
                // hand the result over once the output register is free or is being taken
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_cut     = cut_ext[rhss_pkg::CUT_W-1:0];
                    n_o_cost    = r_best;
                    n_o_found   = r_found;
                    n_o_dflt    = r_dflt;
                    n_o_mean    = r_mean;
                    n_cnt       = '0;
                    n_tw        = '0;
                    n_ts        = '0;
                    n_state     = rhss_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = rhss_pkg::ST_LOAD;
            end
        endcase
    end

    // control and histogram registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rhss_pkg::ST_LOAD;
            r_issued    <= 1'b0;
            r_cnt       <= '0;
            r_i         <= '0;
            r_tw        <= '0;
            r_ts        <= '0;
            r_sq        <= '0;
            r_best      <= '0;
            r_best_cut  <= CNT_W'(1);
            r_found     <= 1'b0;
            r_margin    <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_cnt       <= n_cnt;
            r_i         <= n_i;
            r_tw        <= n_tw;
            r_ts        <= n_ts;
            r_sq        <= n_sq;
            r_best      <= n_best;
            r_best_cut  <= n_best_cut;
            r_found     <= n_found;
            r_margin    <= n_margin;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_wl      <= n_wl;
        r_wr      <= n_wr;
        r_sl      <= n_sl;
        r_sr      <= n_sr;
        r_prod    <= n_prod;
        r_xa      <= n_xa;
        r_qa      <= n_qa;
        r_cost    <= n_cost;
        r_dflt    <= n_dflt;
        r_mean    <= n_mean;
        r_o_cut   <= n_o_cut;
        r_o_cost  <= n_o_cost;
        r_o_found <= n_o_found;
        r_o_dflt  <= n_o_dflt;
        r_o_mean  <= n_o_mean;
    end

    assign o_valid           = r_out_valid;
    assign o_split_bin       = r_o_cut;
    assign o_best_cost       = r_o_cost;
    assign o_found           = r_o_found;
    assign o_base_cost       = r_o_dflt;
    assign o_prediction_mean = r_o_mean;

`ifndef SYNTHESIS
    // bin count never passes the RAM depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BINS))
        else $error("bin count beyond depth");

    // a found cut lies strictly inside the loaded bins
    a_cut_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rhss_pkg::ST_FIN && r_found) |->
            (r_best_cut >= CNT_W'(1) && r_best_cut < r_cnt))
        else $error("best cut out of range");

    // the arithmetic unit finishes only for an operation the search issued
    a_mdu_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_done |-> r_issued)
        else $error("unexpected arithmetic completion");

    // a new result is loaded only into a free or draining output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rhss_pkg::ST_FIN && r_out_valid && i_stall) |=> r_out_valid)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire
